// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker module of the label encoder.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

// Next-cycle implication that is checked during reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== rtl/dnle_pkg.sv =====
// Shared types and constants of the DNS name label encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dnle_pkg;

   localparam int MAX_LABEL = 62;
   localparam int CNT_W     = $clog2(MAX_LABEL + 1);
   localparam int ADDR_W    = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

   localparam logic [7:0] DOT_CHAR = 8'd46;

   // Output byte source.
   localparam logic [1:0] SEL_LEN  = 2'd0;
   localparam logic [1:0] SEL_CHAR = 2'd1;
   localparam logic [1:0] SEL_ZERO = 2'd2;

   typedef struct packed {
      logic [7:0] char_in;
      logic       is_terminator;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       run_last;
      logic       name_done;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      logic       store_char;
      logic       cnt_clr;
      logic       ovf_clr;
      logic       idx_clr;
      logic       idx_inc;
      logic       rd_en;
      logic       out_load;
      logic [1:0] out_sel;
      logic       out_last;
      logic       out_done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic idx_end;
      logic out_free;
      logic req_dot;
   } ctrl_stat_type;

endpackage

// ===== rtl/dnle_ctrl.sv =====
// Sequencer of the label encoder: accepts beats and steps through label flushes.
// Depends on dnle_pkg; drives dnle_dpath through command and status structs.
`timescale 1ns / 1ps

module dnle_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_term,
   output logic                   req_stall,
   input  dnle_pkg::ctrl_stat_type stat,
   output dnle_pkg::ctrl_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LEN  = 3'd1;
   localparam logic [2:0] ST_RD   = 3'd2;
   localparam logic [2:0] ST_EMIT = 3'd3;
   localparam logic [2:0] ST_ZERO = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       term_ff, term_in;

   always_comb begin
      state_in  = state_ff;
      term_in   = term_ff;
      cmd       = '0;
      cmd.out_sel = dnle_pkg::SEL_LEN;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_term) begin
                  term_in  = 1'b1;
                  state_in = stat.cnt_zero ? ST_ZERO : ST_LEN;
               end else if (stat.req_dot) begin
                  term_in  = 1'b0;
                  state_in = ST_LEN;
               end else begin
                  cmd.store_char = 1'b1;
               end
            end
         end
         ST_LEN: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = dnle_pkg::SEL_LEN;
               // Only a dot reaches here with an empty label.
               cmd.out_last = stat.cnt_zero;
               cmd.idx_clr  = 1'b1;
               if (stat.cnt_zero) begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = dnle_pkg::SEL_CHAR;
               cmd.out_last = stat.idx_end && !term_ff;
               cmd.idx_inc  = 1'b1;
               if (stat.idx_end) begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = term_ff ? ST_ZERO : ST_IDLE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_ZERO: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = dnle_pkg::SEL_ZERO;
               cmd.out_last = 1'b1;
               cmd.out_done = 1'b1;
               cmd.cnt_clr  = 1'b1;
               cmd.ovf_clr  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

endmodule

// ===== rtl/dnle_dpath.sv =====
// Datapath of the label encoder: label memory, counters and the output register.
// Depends on dnle_pkg; commanded by dnle_ctrl.
`timescale 1ns / 1ps

module dnle_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  dnle_pkg::req_type       req_data,
   input  dnle_pkg::ctrl_cmd_type  cmd,
   output dnle_pkg::ctrl_stat_type stat,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output dnle_pkg::rsp_type       rsp_data
);

   logic [7:0]                   label_store_ff [dnle_pkg::MAX_LABEL];
   logic [7:0]                   rd_data_ff;
   logic [dnle_pkg::CNT_W-1:0]   label_count_ff, label_count_in;
   logic                         overflow_seen_ff, overflow_seen_in;
   logic [dnle_pkg::ADDR_W-1:0]  idx_ff, idx_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   dnle_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   logic                         cnt_full;
   logic                         do_write;

   assign cnt_full = (label_count_ff == dnle_pkg::CNT_W'(dnle_pkg::MAX_LABEL));
   assign do_write = cmd.store_char && !cnt_full;

   assign stat.cnt_zero = (label_count_ff == '0);
   assign stat.idx_end  = ((dnle_pkg::CNT_W'(idx_ff) + 1'b1) == label_count_ff);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign stat.req_dot  = (req_data.char_in == dnle_pkg::DOT_CHAR);

   always_comb begin
      label_count_in = label_count_ff;
      if (cmd.cnt_clr) begin
         label_count_in = '0;
      end else if (do_write) begin
         label_count_in = label_count_ff + 1'b1;
      end
   end

   // Characters past the label limit are dropped and mark the whole name.
   always_comb begin
      overflow_seen_in = overflow_seen_ff;
      if (cmd.ovf_clr) begin
         overflow_seen_in = 1'b0;
      end else if (cmd.store_char && cnt_full) begin
         overflow_seen_in = 1'b1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.out_load) begin
         case (cmd.out_sel)
            dnle_pkg::SEL_LEN:  rsp_data_in.byte_out = 8'(label_count_ff);
            dnle_pkg::SEL_CHAR: rsp_data_in.byte_out = rd_data_ff;
            default:            rsp_data_in.byte_out = 8'd0;
         endcase
         rsp_data_in.run_last  = cmd.out_last;
         rsp_data_in.name_done = cmd.out_done;
         rsp_data_in.overflow  = overflow_seen_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         label_store_ff[label_count_ff[dnle_pkg::ADDR_W-1:0]] <= req_data.char_in;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= label_store_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_count_ff   <= '0;
         overflow_seen_ff <= 1'b0;
         idx_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         label_count_ff   <= label_count_in;
         overflow_seen_ff <= overflow_seen_in;
         idx_ff           <= idx_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/dns_name_label_encoder.sv =====
// DNS name label encoder: dotted name in, one character per beat; wire form out.
// Usage: req_data carries char_in and is_terminator; a beat moves on valid high,
// stall low. Plain characters are buffered in a label memory and give no output.
// A dot emits the length byte and the buffered characters; the terminator emits
// the pending label if it is not empty, then the closing zero with name_done.
// run_last marks the final rsp beat caused by one req beat.
// A plain character never stalls the input. A flush steps through the
// accepting beat, the length byte, and a read and an emit per character, since
// the label memory has one registered read port; the closing zero comes last.
// The length byte is loaded in ST_LEN, once the output register is free.
// The output register lets a new req beat in while the last rsp beat waits.
// A stall on rsp holds rsp_data and pauses the flush; req_stall is high while
// a flush is in progress. Reset clears the label count and overflow flag and
// drops any pending rsp beat; the memory itself is not cleared.
// Depends on dnle_pkg, dnle_ctrl and dnle_dpath.
`timescale 1ns / 1ps

module dns_name_label_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dnle_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dnle_pkg::rsp_type rsp_data
);

   dnle_pkg::ctrl_cmd_type  cmd;
   dnle_pkg::ctrl_stat_type stat;

   dnle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_term  (req_data.is_terminator),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dnle_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/dnle_checker.sv =====
// Port-level checks for the DNS name label encoder, bound to the top level.
// Depends on dnle_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dnle_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input dnle_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dnle_pkg::rsp_type rsp_data
);

   // A stalled result beat stays put.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // The closing zero is always the final beat of its request.
   `ASSERT_IMPL(a_done_zero, clock, reset, rsp_valid && rsp_data.name_done, rsp_data.byte_out == 8'd0 && rsp_data.run_last)

   // A plain character is only buffered, so the next beat can follow at once.
   `ASSERT_NEXT(a_plain_char, clock, reset, req_valid && !req_stall && !req_data.is_terminator && req_data.char_in != dnle_pkg::DOT_CHAR, !req_stall)

   // Reset drops any pending result.
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (.*);

// ===== tb/sv/dns_name_label_encoder_tb.sv =====
// Self-checking testbench for dns_name_label_encoder: dotted names go in one
// character per beat, and the encoded wire bytes are checked against a predictor.
// Depends on dnle_pkg and the dns_name_label_encoder RTL.
`timescale 1ns / 1ps

module dns_name_label_encoder_tb;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   dnle_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   dnle_pkg::rsp_type rsp_data;

   // Predictor state: the pending label and the sticky overflow of the current name.
   logic [7:0]        pend_label [dnle_pkg::MAX_LABEL];
   int                pend_len;
   logic              name_ovf;
   dnle_pkg::rsp_type wire_bytes_q [$];

   int fail_count;
   int beats_sent;
   int send_idle_pct;
   int recv_idle_pct;

   dns_name_label_encoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // Emits the length byte and the buffered characters. On a dot the last
   // byte of the flush closes the beat; before a terminator it does not.
   function automatic void flush_label(input logic mark_last);
      logic [7:0] len;
      len = 8'(pend_len);
      wire_bytes_q.push_back({len, mark_last && (pend_len == 0), 1'b0, name_ovf});
      for (int i = 0; i < pend_len; i++) begin
         wire_bytes_q.push_back({pend_label[i], mark_last && (i == pend_len - 1),
                                 1'b0, name_ovf});
      end
      pend_len = 0;
   endfunction

   function automatic void encode_char(input dnle_pkg::req_type b);
      if (b.is_terminator) begin
         if (pend_len != 0) begin
            flush_label(1'b0);
         end
         wire_bytes_q.push_back({8'd0, 1'b1, 1'b1, name_ovf});
         pend_len = 0;
         name_ovf = 1'b0;
      end else if (b.char_in == dnle_pkg::DOT_CHAR) begin
         flush_label(1'b1);
      end else if (pend_len < dnle_pkg::MAX_LABEL) begin
         pend_label[pend_len] = b.char_in;
         pend_len++;
      end else begin
         name_ovf = 1'b1;
      end
   endfunction

   task automatic send_beat(input logic [7:0] c, input logic term);
      dnle_pkg::req_type b;
      b.char_in       = c;
      b.is_terminator = term;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      encode_char(b);
      beats_sent++;
   endtask

   // Sends len characters of a label, never a dot.
   task automatic send_label(input int len);
      logic [7:0] c;
      for (int i = 0; i < len; i++) begin
         do c = 8'($urandom_range(255)); while (c == dnle_pkg::DOT_CHAR);
         send_beat(c, 1'b0);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (wire_bytes_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Empty name, leading, doubled and trailing dots, extreme character values,
   // and a terminator whose character field holds a dot.
   task automatic test_special_names();
      send_beat(8'hFF, 1'b1);
      send_beat(dnle_pkg::DOT_CHAR, 1'b0);
      send_beat("a", 1'b0);
      send_beat(8'h00, 1'b1);
      send_beat("a", 1'b0);
      send_beat(dnle_pkg::DOT_CHAR, 1'b0);
      send_beat(dnle_pkg::DOT_CHAR, 1'b0);
      send_beat("b", 1'b0);
      send_beat(dnle_pkg::DOT_CHAR, 1'b0);
      send_beat(dnle_pkg::DOT_CHAR, 1'b1);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h01, 1'b0);
      send_beat(8'hFE, 1'b0);
      send_beat(8'h5A, 1'b1);
   endtask

   // A label one past the maximum length fills the memory and drops a
   // character: the overflow must stick through the next label and clear once
   // the name ends.
   task automatic test_long_labels();
      send_label(dnle_pkg::MAX_LABEL + 1);
      send_beat(dnle_pkg::DOT_CHAR, 1'b0);
      send_beat("q", 1'b0);
      send_beat(8'h00, 1'b1);
      send_beat("b", 1'b0);
      send_beat(8'hFF, 1'b1);
   endtask

   // Mostly well-formed names with random labels; the rest is random noise.
   task automatic test_random_names(input int count);
      int stop_at;
      int labels;
      stop_at = beats_sent + count;
      while (beats_sent < stop_at) begin
         if ($urandom_range(99) < 15) begin
            send_beat(8'($urandom_range(255)), $urandom_range(7) == 0);
         end else begin
            labels = $urandom_range(1, 4);
            for (int l = 0; l < labels; l++) begin
               send_label($urandom_range(0, 6));
               if (l != labels - 1 || $urandom_range(3) == 0) begin
                  send_beat(dnle_pkg::DOT_CHAR, 1'b0);
               end
            end
            send_beat(8'($urandom_range(255)), 1'b1);
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      dnle_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (wire_bytes_q.size() == 0) begin
            note_failure($sformatf("unexpected beat: byte %h last %b done %b ovf %b",
                                   rsp_data.byte_out, rsp_data.run_last,
                                   rsp_data.name_done, rsp_data.overflow));
         end else begin
            want = wire_bytes_q.pop_front();
            if (rsp_data.byte_out !== want.byte_out || rsp_data.run_last !== want.run_last
                || rsp_data.name_done !== want.name_done
                || rsp_data.overflow !== want.overflow) begin
               note_failure($sformatf(
                  "mismatch: exp byte %h last %b done %b ovf %b, got %h %b %b %b",
                  want.byte_out, want.run_last, want.name_done, want.overflow,
                  rsp_data.byte_out, rsp_data.run_last, rsp_data.name_done,
                  rsp_data.overflow));
            end
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      pend_len      = 0;
      name_ovf      = 1'b0;
      fail_count    = 0;
      beats_sent    = 0;
      send_idle_pct = 23;
      recv_idle_pct = 74;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_special_names();
      test_long_labels();
      test_random_names(6);
      wait_drained();

      send_idle_pct = 74;
      recv_idle_pct = 23;
      test_random_names(6);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_names(6);
      wait_drained();

      repeat (20) @(posedge clock);
      if (wire_bytes_q.size() != 0) begin
         note_failure($sformatf("%0d expected beats never arrived", wire_bytes_q.size()));
      end
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
